[src/sgpk_pkg.sv]
// ----------------------------------------------------------------------------
// sgpk_pkg
// Shared widths, register codes and types of the softened gravity pair kick.
// ----------------------------------------------------------------------------
package sgpk_pkg;

   localparam int CHUNK_W    = 32;
   localparam int MUL_LAT    = 3;
   localparam int AXES       = 3;
   localparam int LANES      = 2 * AXES;
   localparam int POS_W      = 32;
   localparam int MASS_W     = 32;
   localparam int CFG_W      = 32;
   localparam int K_W        = MASS_W + 2 * CFG_W;
   localparam int KICK_W     = 48;
   localparam int MAG_W      = KICK_W - 1;
   localparam int KICK_SHIFT = 8;
   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] REG_TIME_STEP  = 2'd0;
   localparam logic [1:0] REG_GRAV_CONST = 2'd1;
   localparam logic [1:0] REG_SOFTENING  = 2'd2;
   localparam logic [1:0] REG_METERS     = 2'd3;

   localparam logic [CFG_W-1:0] TIME_STEP_RST  = 32'd65536;
   localparam logic [CFG_W-1:0] GRAV_CONST_RST = 32'd1;
   localparam logic [CFG_W-1:0] SOFTENING_RST  = 32'd0;
   localparam logic [CFG_W-1:0] METERS_RST     = 32'd65536;

   typedef logic [KICK_W-1:0] kick_type;

endpackage

[src/sgpk_mul.sv]
// ----------------------------------------------------------------------------
// sgpk_mul
// Pipelined unsigned multiplier: 32x32 partial products, then row and final sums.
// ----------------------------------------------------------------------------
module sgpk_mul #(
   parameter int A_W = 32,
   parameter int B_W = 32
) (
   input  logic               clock,
   input  logic               en,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic [A_W+B_W-1:0] p
);
   import sgpk_pkg::*;

   localparam int NA = (A_W + CHUNK_W - 1) / CHUNK_W;
   localparam int NB = (B_W + CHUNK_W - 1) / CHUNK_W;
   localparam int RW = CHUNK_W * (NA + 2);
   localparam int FW = RW + CHUNK_W * NB;

   logic [NA*CHUNK_W-1:0] a_x;
   logic [NB*CHUNK_W-1:0] b_x;
   logic [2*CHUNK_W-1:0]  pp_ff [NB][NA];
   logic [RW-1:0]         row_in [NB];
   logic [RW-1:0]         row_ff [NB];
   logic [FW-1:0]         sum_in;
   logic [FW-1:0]         sum_ff;

   assign a_x = (NA*CHUNK_W)'(a);
   assign b_x = (NB*CHUNK_W)'(b);

   // even and odd partial products do not overlap within a row
   always_comb begin : row_sum
      logic [RW-1:0] ev;
      logic [RW-1:0] od;
      for (int j = 0; j < NB; j++) begin
         ev = '0;
         od = '0;
         for (int i = 0; i < NA; i++) begin
            if (i % 2 == 0) begin
               ev[CHUNK_W*i +: 2*CHUNK_W] = pp_ff[j][i];
            end else begin
               od[CHUNK_W*i +: 2*CHUNK_W] = pp_ff[j][i];
            end
         end
         row_in[j] = ev + od;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int j = 0; j < NB; j++) begin
         sum_in = sum_in + (FW'(row_ff[j]) << (CHUNK_W * j));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < NB; j++) begin
            for (int i = 0; i < NA; i++) begin
               pp_ff[j][i] <= a_x[CHUNK_W*i +: CHUNK_W] * b_x[CHUNK_W*j +: CHUNK_W];
            end
            row_ff[j] <= row_in[j];
         end
         sum_ff <= sum_in;
      end
   end

   assign p = sum_ff[A_W+B_W-1:0];

endmodule

[src/sgpk_dly.sv]
// ----------------------------------------------------------------------------
// sgpk_dly
// Stallable delay line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module sgpk_dly #(
   parameter int W = 1,
   parameter int D = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] tap_ff [D];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int k = 1; k < D; k++) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign dout = tap_ff[D-1];

endmodule

[src/sgpk_sqrt.sv]
// ----------------------------------------------------------------------------
// sgpk_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module sgpk_sqrt #(
   parameter int X_W = 8,
   localparam int R_W = (X_W + 1) / 2
) (
   input  logic           clock,
   input  logic           en,
   input  logic [X_W-1:0] x,
   output logic [R_W-1:0] root
);

   localparam int XE = 2 * R_W + 1;

   logic [XE-1:0]  x_in [R_W];
   logic [XE-1:0]  x_ff [R_W];
   logic [R_W-1:0] r_in [R_W];
   logic [R_W-1:0] r_ff [R_W];

   // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
   always_comb begin : stages
      logic [XE-1:0]  xi;
      logic [XE-1:0]  cand;
      logic [R_W-1:0] ri;
      int             b;
      for (int k = 0; k < R_W; k++) begin
         if (k == 0) begin
            xi = XE'(x);
            ri = '0;
         end else begin
            xi = x_ff[k-1];
            ri = r_ff[k-1];
         end
         b    = R_W - 1 - k;
         cand = (XE'(ri) << (b + 1)) | (XE'(1) << (2 * b));
         if (xi >= cand) begin
            x_in[k] = xi - cand;
            r_in[k] = ri | (R_W'(1) << b);
         end else begin
            x_in[k] = xi;
            r_in[k] = ri;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < R_W; k++) begin
            x_ff[k] <= x_in[k];
            r_ff[k] <= r_in[k];
         end
      end
   end

   assign root = r_ff[R_W-1];

endmodule

[src/sgpk_div.sv]
// ----------------------------------------------------------------------------
// sgpk_div
// Pipelined restoring divider with overflow check, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sgpk_div #(
   parameter int N_W = 16,
   parameter int D_W = 16,
   parameter int Q_W = 8
) (
   input  logic           clock,
   input  logic           en,
   input  logic [N_W-1:0] num,
   input  logic [D_W-1:0] den,
   output logic [Q_W-1:0] quo,
   output logic           ovf
);

   localparam int X_W = (N_W > D_W + Q_W + 1) ? N_W : D_W + Q_W + 1;

   logic [X_W-1:0] rem_in [Q_W+1];
   logic [X_W-1:0] rem_ff [Q_W+1];
   logic [D_W-1:0] den_in [Q_W+1];
   logic [D_W-1:0] den_ff [Q_W+1];
   logic [Q_W-1:0] q_in   [Q_W+1];
   logic [Q_W-1:0] q_ff   [Q_W+1];
   logic           ovf_in [Q_W+1];
   logic           ovf_ff [Q_W+1];

   always_comb begin : stages
      logic [X_W-1:0] sh;
      int             b;
      rem_in[0] = X_W'(num);
      den_in[0] = den;
      q_in[0]   = '0;
      ovf_in[0] = X_W'(num) >= (X_W'(den) << Q_W);
      for (int k = 1; k <= Q_W; k++) begin
         b         = Q_W - k;
         sh        = X_W'(den_ff[k-1]) << b;
         den_in[k] = den_ff[k-1];
         ovf_in[k] = ovf_ff[k-1];
         if (rem_ff[k-1] >= sh) begin
            rem_in[k] = rem_ff[k-1] - sh;
            q_in[k]   = q_ff[k-1] | (Q_W'(1) << b);
         end else begin
            rem_in[k] = rem_ff[k-1];
            q_in[k]   = q_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= Q_W; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_in[k];
            q_ff[k]   <= q_in[k];
            ovf_ff[k] <= ovf_in[k];
         end
      end
   end

   assign quo = q_ff[Q_W];
   assign ovf = ovf_ff[Q_W];

endmodule

[src/softened_gravity_pair_kick.sv]
// Throughput: one transaction per cycle while the skid register is empty, set by the fully
// pipelined square root and dividers.
// A stalled result waits in a one-entry skid register; the pipeline holds while it is full.
// Reset clears the valid bits and the skid full flag and loads the register defaults.
// ----------------------------------------------------------------------------
// softened_gravity_pair_kick
// Pair velocity kick from softened gravity, one pair per unstalled cycle, saturating Q24.24.
// ----------------------------------------------------------------------------
module softened_gravity_pair_kick #(
   parameter int POS_FRAC_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, mass_a, mass_b
   input  logic [255:0]                            req_tdata,
   // symmetric
   input  logic [0:0]                              req_tuser,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // kick_a_x, kick_a_y, kick_a_z, kick_b_x, kick_b_y, kick_b_z
   output logic [287:0]                            rsp_tdata,
   // coincident
   output logic [0:0]                              rsp_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [sgpk_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [sgpk_pkg::CFG_W-1:0]              csr_pwdata,
   output logic [sgpk_pkg::CFG_W-1:0]              csr_prdata,
   output logic                                    csr_pready
);
   import sgpk_pkg::*;

   localparam int DIFF_W  = POS_W + 1;
   localparam int PW      = DIFF_W + CFG_W;
   localparam int UW      = PW - POS_FRAC_BITS;
   localparam int SW      = 2 * UW + 2;
   localparam int DW      = (SW + 1) / 2;
   localparam int EW      = 2 * DW + 1;
   localparam int NW      = EW + DW;
   localparam int NUM_W   = K_W + UW;
   localparam int DIV_N_W = NUM_W + KICK_SHIFT;
   localparam int T_NUM   = 1 + 2 * MUL_LAT;
   localparam int T_D2    = T_NUM + 1;
   localparam int T_D     = T_D2 + DW;
   localparam int T_DEN   = T_D + 2 * MUL_LAT + 1;
   localparam int T_Q     = T_DEN + MAG_W + 1;
   localparam int LAT     = T_Q + 1;

   logic [CFG_W-1:0] time_step_ff, grav_const_ff, softening_ff, meters_ff;
   logic [2*CFG_W-1:0] c_ff, s2_ff;
   logic en, csr_wr;

   logic [LAT-1:0] vld_ff;
   logic           skid_full_ff;

   logic [DIFF_W-1:0] diff   [AXES];
   logic [AXES-1:0]   neg_c;
   logic [DIFF_W-1:0] mag_ff [AXES];
   logic [MASS_W-1:0] ma_ff, mb_ff;

   logic [PW-1:0]     scaled  [AXES];
   logic [UW-1:0]     u       [AXES];
   logic [2*UW-1:0]   u2      [AXES];
   logic [SW-1:0]     d2_in, d2_ff;
   logic [DW-1:0]     d, d_q;
   logic [2*DW-1:0]   dd;
   logic [EW-1:0]     e_in, e_ff;
   logic [NW-1:0]     den;
   logic [K_W-1:0]    k_side  [2];
   logic [NUM_W-1:0]  num     [LANES];
   logic [NUM_W-1:0]  num_q   [LANES];
   logic [MAG_W-1:0]  quo     [LANES];
   logic [LANES-1:0]  ovf;

   logic [AXES:0]     flags_q;
   logic              coin_q;
   kick_type          kick_in      [LANES];
   kick_type          kick_ff      [LANES];
   kick_type          skid_kick_ff [LANES];
   logic              coin_ff, skid_coin_ff;

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff  <= TIME_STEP_RST;
         grav_const_ff <= GRAV_CONST_RST;
         softening_ff  <= SOFTENING_RST;
         meters_ff     <= METERS_RST;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_TIME_STEP:  time_step_ff  <= csr_pwdata;
            REG_GRAV_CONST: grav_const_ff <= csr_pwdata;
            REG_SOFTENING:  softening_ff  <= csr_pwdata;
            REG_METERS:     meters_ff     <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_TIME_STEP:  csr_prdata = time_step_ff;
         REG_GRAV_CONST: csr_prdata = grav_const_ff;
         REG_SOFTENING:  csr_prdata = softening_ff;
         REG_METERS:     csr_prdata = meters_ff;
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      c_ff  <= (2*CFG_W)'(time_step_ff) * (2*CFG_W)'(grav_const_ff);
      s2_ff <= (2*CFG_W)'(softening_ff) * (2*CFG_W)'(softening_ff);
   end

   // ---------------- flow control ----------------
   assign en         = ~skid_full_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // ---------------- difference and scaling ----------------
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         diff[i]  = {req_tdata[POS_W*i+POS_W-1], req_tdata[POS_W*i +: POS_W]}
                  - {req_tdata[POS_W*(i+AXES)+POS_W-1], req_tdata[POS_W*(i+AXES) +: POS_W]};
         neg_c[i] = diff[i][DIFF_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < AXES; i++) begin
            mag_ff[i] <= neg_c[i] ? -diff[i] : diff[i];
         end
         ma_ff <= req_tdata[POS_W*LANES +: MASS_W];
         mb_ff <= req_tdata[POS_W*LANES+MASS_W +: MASS_W];
      end
   end

   for (genvar i = 0; i < AXES; i++) begin : g_axis
      sgpk_mul #(.A_W(DIFF_W), .B_W(CFG_W)) u_scale (
         .clock(clock), .en(en), .a(mag_ff[i]), .b(meters_ff), .p(scaled[i])
      );
      assign u[i] = scaled[i][PW-1:POS_FRAC_BITS];
      sgpk_mul #(.A_W(UW), .B_W(UW)) u_square (
         .clock(clock), .en(en), .a(u[i]), .b(u[i]), .p(u2[i])
      );
   end

   sgpk_mul #(.A_W(MASS_W), .B_W(2*CFG_W)) u_k_a (
      .clock(clock), .en(en), .a(mb_ff), .b(c_ff), .p(k_side[0])
   );
   sgpk_mul #(.A_W(MASS_W), .B_W(2*CFG_W)) u_k_b (
      .clock(clock), .en(en), .a(ma_ff), .b(c_ff), .p(k_side[1])
   );

   // ---------------- distance and denominator ----------------
   assign d2_in = SW'(u2[0]) + SW'(u2[1]) + SW'(u2[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff <= d2_in;
         e_ff  <= e_in;
      end
   end

   sgpk_sqrt #(.X_W(SW)) u_sqrt (.clock(clock), .en(en), .x(d2_ff), .root(d));

   sgpk_mul #(.A_W(DW), .B_W(DW)) u_dsq (
      .clock(clock), .en(en), .a(d), .b(d), .p(dd)
   );
   sgpk_dly #(.W(DW), .D(MUL_LAT + 1)) u_d_dly (
      .clock(clock), .en(en), .din(d), .dout(d_q)
   );

   assign e_in = EW'(dd) + EW'(s2_ff);

   sgpk_mul #(.A_W(EW), .B_W(DW)) u_den (
      .clock(clock), .en(en), .a(e_ff), .b(d_q), .p(den)
   );

   // ---------------- numerators and division ----------------
   for (genvar j = 0; j < LANES; j++) begin : g_lane
      sgpk_mul #(.A_W(K_W), .B_W(UW)) u_num (
         .clock(clock), .en(en), .a(k_side[j/AXES]), .b(u[j%AXES]), .p(num[j])
      );
      sgpk_dly #(.W(NUM_W), .D(T_DEN - T_NUM)) u_num_dly (
         .clock(clock), .en(en), .din(num[j]), .dout(num_q[j])
      );
      sgpk_div #(.N_W(DIV_N_W), .D_W(NW), .Q_W(MAG_W)) u_div (
         .clock(clock), .en(en),
         .num({num_q[j], {KICK_SHIFT{1'b0}}}), .den(den),
         .quo(quo[j]), .ovf(ovf[j])
      );
   end

   sgpk_dly #(.W(AXES + 1), .D(T_Q)) u_flag_dly (
      .clock(clock), .en(en), .din({req_tuser[0], neg_c}), .dout(flags_q)
   );
   sgpk_dly #(.W(1), .D(T_Q - T_D2)) u_coin_dly (
      .clock(clock), .en(en), .din(d2_ff == '0), .dout(coin_q)
   );

   // ---------------- sign, saturation, output ----------------
   function automatic kick_type sat_kick(logic [MAG_W-1:0] q, logic over, logic negk);
      kick_type m;
      m = over ? {1'b0, {MAG_W{1'b1}}} : {1'b0, q};
      if (negk) begin
         m = over ? {1'b1, {MAG_W{1'b0}}} : -m;
      end
      return m;
   endfunction

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         if (coin_q || (j >= AXES && !flags_q[AXES])) begin
            kick_in[j] = '0;
         end else if (j < AXES) begin
            kick_in[j] = sat_kick(quo[j], ovf[j], !flags_q[j%AXES]);
         end else begin
            kick_in[j] = sat_kick(quo[j], ovf[j], flags_q[j%AXES]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kick_ff <= kick_in;
         coin_ff <= coin_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else if (!skid_full_ff) begin
         if (vld_ff[LAT-1] && !rsp_tready) begin
            skid_full_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         skid_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff) begin
         skid_kick_ff <= kick_ff;
         skid_coin_ff <= coin_ff;
      end
   end

   assign rsp_tvalid = skid_full_ff | vld_ff[LAT-1];

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         rsp_tdata[KICK_W*j +: KICK_W] = skid_full_ff ? skid_kick_ff[j] : kick_ff[j];
      end
      rsp_tuser[0] = skid_full_ff ? skid_coin_ff : coin_ff;
   end

   // ---------------- assertions ----------------
   a_coin_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("coincident result carries nonzero kick");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(vld_ff[LAT-1] && !rsp_tready))
      else $error("skid filled without a stalled result");

   a_skid_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |=> !skid_full_ff)
      else $error("skid filled while no result was present");

endmodule

[bench/softened_gravity_pair_kick_tb.sv]
// ----------------------------------------------------------------------------
// softened_gravity_pair_kick_tb
// Self-checking bench: drives pair transactions and CSR writes, predicts each
// kick result with wide integer arithmetic and compares every field in order.
// ----------------------------------------------------------------------------
module softened_gravity_pair_kick_tb;
   import sgpk_pkg::*;

   localparam int FRAC       = 16;
   localparam int CYCLE_CAP  = 400000;
   localparam int SETTLE     = 220;

   typedef struct {
      logic [POS_W-1:0]  pos [AXES*2];
      logic [MASS_W-1:0] mass_a;
      logic [MASS_W-1:0] mass_b;
      logic              sym;
   } pair_type;

   typedef struct {
      kick_type kick [LANES];
      logic     coinc;
   } kicks_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [255:0]          req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [287:0]          rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CFG_W-1:0]      csr_pwdata = '0;
   logic [CFG_W-1:0]      csr_prdata;
   logic                  csr_pready;

   logic [CFG_W-1:0] dt_reg, g_reg, soft_reg, mpu_reg;
   kicks_type        kick_queue [$];
   int               mismatches = 0;
   int               cycles = 0;
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   int               hold_off = 0;

   softened_gravity_pair_kick #(.POS_FRAC_BITS(FRAC)) dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [255:0] int_sqrt(logic [255:0] v);
      logic [255:0] r;
      logic [255:0] t;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (256'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic kick_type to_kick(logic [255:0] q, logic neg);
      logic [63:0] m;
      m = q[63:0];
      if (q > 256'h7FFF_FFFF_FFFF) m = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
      return neg ? kick_type'(48'd0 - m[47:0]) : m[47:0];
   endfunction

   function automatic kicks_type predict_kicks(pair_type p);
      kicks_type    e;
      logic signed [33:0] diff;
      logic [255:0] u [AXES];
      logic         neg [AXES];
      logic [255:0] d2, d, den, ka, kb, c;
      d2 = '0;
      for (int i = 0; i < AXES; i++) begin
         diff = $signed({{2{p.pos[i][31]}}, p.pos[i]})
              - $signed({{2{p.pos[i+3][31]}}, p.pos[i+3]});
         neg[i] = diff < 0;
         u[i] = ((neg[i] ? 256'(-diff) : 256'(diff)) * 256'(mpu_reg)) >> FRAC;
         d2 = d2 + u[i] * u[i];
      end
      d = int_sqrt(d2);
      e.coinc = (d == 0);
      for (int i = 0; i < LANES; i++) e.kick[i] = '0;
      if (d != 0) begin
         den = (d * d + 256'(soft_reg) * 256'(soft_reg)) * d;
         c = 256'(dt_reg) * 256'(g_reg);
         ka = c * (256'(p.mass_b) << KICK_SHIFT);
         kb = c * (256'(p.mass_a) << KICK_SHIFT);
         for (int i = 0; i < AXES; i++) begin
            e.kick[i] = to_kick((ka * u[i]) / den, !neg[i]);
            if (p.sym) e.kick[i+3] = to_kick((kb * u[i]) / den, neg[i]);
         end
      end
      return e;
   endfunction

   // result checker
   always @(posedge clock) begin
      kicks_type e;
      logic      bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (kick_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction %h", rsp_tdata);
         end else begin
            e = kick_queue.pop_front();
            bad = (rsp_tuser[0] !== e.coinc);
            for (int i = 0; i < LANES; i++)
               if (rsp_tdata[i*KICK_W +: KICK_W] !== e.kick[i]) bad = 1'b1;
            if (bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("kick mismatch: coincident exp %b got %b", e.coinc, rsp_tuser[0]);
                  for (int i = 0; i < LANES; i++)
                     $display("  lane %0d exp %h got %h", i, e.kick[i],
                              rsp_tdata[i*KICK_W +: KICK_W]);
               end
            end
         end
      end
   end

   // receiver
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_TIME_STEP:  dt_reg = val;
         REG_GRAV_CONST: g_reg = val;
         REG_SOFTENING:  soft_reg = val;
         default:        mpu_reg = val;
      endcase
   endtask

   task automatic set_config(logic [31:0] dt, logic [31:0] g, logic [31:0] s,
                             logic [31:0] m);
      csr_write(REG_TIME_STEP, dt);
      csr_write(REG_GRAV_CONST, g);
      csr_write(REG_SOFTENING, s);
      csr_write(REG_METERS, m);
   endtask

   task automatic drain();
      while (kick_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // called right after a falling edge; returns right after a falling edge
   task automatic send_pair(pair_type p);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      for (int i = 0; i < 6; i++) req_tdata[i*32 +: 32] <= p.pos[i];
      req_tdata[192 +: 32] <= p.mass_a;
      req_tdata[224 +: 32] <= p.mass_b;
      req_tuser[0] <= p.sym;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      kick_queue.push_back(predict_kicks(p));
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic pair_type random_pair();
      pair_type p;
      int       near;
      near = $urandom_range(99);
      for (int i = 0; i < 3; i++) begin
         p.pos[i] = $urandom();
         if (near < 60) p.pos[i+3] = p.pos[i] + ($urandom() >> $urandom_range(8, 31))
                                   - ($urandom() >> $urandom_range(8, 31));
         else if (near < 63) p.pos[i+3] = p.pos[i];
         else p.pos[i+3] = $urandom();
      end
      p.mass_a = ($urandom_range(19) == 0) ? 32'd0 : $urandom() >> $urandom_range(0, 24);
      p.mass_b = ($urandom_range(19) == 0) ? 32'd0 : $urandom() >> $urandom_range(0, 24);
      p.sym = $urandom_range(1);
      return p;
   endfunction

   function automatic pair_type make_pair(logic [31:0] ax, logic [31:0] bx, logic [31:0] ma,
                                          logic [31:0] mb, logic sym);
      pair_type p;
      p.pos[0] = ax; p.pos[1] = ax; p.pos[2] = ax;
      p.pos[3] = bx; p.pos[4] = bx; p.pos[5] = bx;
      p.mass_a = ma; p.mass_b = mb; p.sym = sym;
      return p;
   endfunction

   task automatic test_directed();
      pair_type p;
      send_idle_pct = 0; stall_pct = 0;
      set_config(TIME_STEP_RST, GRAV_CONST_RST, SOFTENING_RST, METERS_RST);
      send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
      send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd1, 1));
      send_pair(make_pair(32'h0001_0000, 32'h0001_0000, 32'd65536, 32'd65536, 1));
      send_pair(make_pair(32'h0002_0000, 32'h0000_0000, 32'd0, 32'd65536, 1));
      send_pair(make_pair(32'h0000_0000, 32'h0002_0000, 32'd65536, 32'd0, 0));
      p = make_pair(32'h0001_0000, 32'h0, 32'h10000, 32'h10000, 1);
      p.pos[1] = 32'h0; p.pos[2] = 32'hFFFF_0000;
      send_pair(p);
      end_burst();
      drain();
      // saturation
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
      send_pair(make_pair(32'h0000_0001, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
      send_pair(make_pair(32'h0, 32'h0000_0100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
      send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1, 1));
      send_pair(make_pair(32'h1234_5678, 32'h1234_5678, 32'h5, 32'h5, 1));
      end_burst();
      drain();
      // tiny scale truncates a small offset to zero distance
      set_config(32'h10000, 32'h10000, 32'hFFFF_FFFF, 32'd1);
      send_pair(make_pair(32'h1, 32'h0, 32'h10000, 32'h10000, 1));
      send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h10000, 32'h10000, 1));
      send_pair(make_pair(32'h0, 32'h10, 32'h10000, 32'h10000, 0));
      end_burst();
      drain();
      set_config(32'h0, 32'h0, 32'h0, 32'h0);
      send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h10000, 32'h10000, 1));
      send_pair(make_pair(32'h100, 32'h0, 32'h10000, 32'h10000, 1));
      end_burst();
      drain();
   endtask

   task automatic test_random(int n, int send_pct, int rx_pct);
      send_idle_pct = send_pct; stall_pct = rx_pct;
      set_config($urandom() >> $urandom_range(0, 16), $urandom() >> $urandom_range(0, 16),
                 $urandom() >> $urandom_range(8, 31), $urandom() >> $urandom_range(0, 16));
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0 && i != 0) begin
            end_burst();
            drain();
            set_config($urandom() >> $urandom_range(0, 31), $urandom() >> $urandom_range(0, 31),
                       $urandom() >> $urandom_range(0, 31),
                       $urandom() >> $urandom_range(0, 16));
         end
         send_pair(random_pair());
      end
      end_burst();
      drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0; stall_pct = 0;
      set_config(32'h10000, 32'h4000_0000, 32'h100, 32'h10000);
      hold_off = 500;
      for (int i = 0; i < 250; i++) send_pair(random_pair());
      end_burst();
      drain();
   endtask

   initial begin
      dt_reg = TIME_STEP_RST; g_reg = GRAV_CONST_RST;
      soft_reg = SOFTENING_RST; mpu_reg = METERS_RST;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random(360, 0, 0);
      test_random(360, 67, 0);
      test_random(360, 0, 67);
      test_random(360, 35, 35);
      test_backpressure();
      if (mismatches == 0 && kick_queue.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
